// File: rtl/exh_pkg.sv
// Shared types and codes for the exception handler table.
package exh_pkg;

    typedef enum logic [1:0] {
        FUNC_HDR    = 2'd0,
        FUNC_ENTRY  = 2'd1,
        FUNC_LOOKUP = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_DUP  = 2'd2,
        ST_SEQ  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_RESOLVE,
        S_SCAN,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch;
        logic    set_stat;
        t_status stat;
        logic    entry_wr;
        logic    hdr_wr;
        logic    walk_start;
        logic    walk_step;
        logic    walk_hit;
        logic    scan_start;
        logic    scan_step;
        logic    scan_hit;
        logic    out_load;
    } t_dp_cmd;

    // Conditions reported by the datapath to the controller.
    typedef struct packed {
        t_func func;
        logic  pending_zero;
        logic  fill_zero;
        logic  fill_full;
        logic  cnt_zero;
        logic  hdr_fits;
        logic  walk_match;
        logic  walk_more;
        logic  hit;
        logic  hdr_cnt_zero;
        logic  scan_first_ok;
        logic  scan_match;
        logic  scan_more;
    } t_dp_stat;

endpackage

// File: rtl/exception_handler_table.sv
// Top level of the exception handler table: controller plus datapath.
//
// The table is one memory of TABLE_DEPTH words of 56 bits holding a run of
// subtables, each a header word (entry count and catch offset) followed by
// its handler entries. A transaction on the input side carries one item:
// a header opens a subtable and reserves room for all of its entries, an
// entry item appends to the open subtable, and a lookup walks the headers
// from word zero, stepping by each header's count, to the one whose catch
// offset matches, then scans that subtable's entries for the requested
// bytecode index and scope depth. Every item yields exactly one result
// transaction. The block works on one item at a time; the memory's single
// read port sets the pace at one table word per cycle. After acceptance an
// item is decoded. A header accepted while a subtable is open is refused
// at once; otherwise a header or lookup walks the stored headers and then
// resolves, and a lookup that finds its subtable scans that subtable's
// entries. Every item ends in a finish state that loads the result
// register, and the input is ready again in the cycle after the load. A
// result that cannot be loaded because the previous one still waits for
// the consumer holds the block in the finish state until that one is taken.
// The output register lets the next item be accepted while a result still
// waits for the consumer. No clearing pass is needed after reset: only words
// below the fill count are ever read.
module exception_handler_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_site_pco,
    input  logic [7:0]  i_handler_count,
    input  logic [15:0] i_handler_bci,
    input  logic [31:0] i_handler_pco,
    input  logic [7:0]  i_scope_depth,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_subtable_found,
    output logic [7:0]  o_subtable_len,
    output logic        o_found,
    output logic [31:0] o_found_pco
);

    exh_pkg::t_dp_cmd  dp_cmd;
    exh_pkg::t_dp_stat dp_stat;

    // The controller decides the flow of each transaction from the datapath's
    // conditions and issues one command set per cycle.
    exh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // The datapath holds the table, counters, walk pointers and result registers.
    exh_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_func           (i_func),
        .i_site_pco       (i_site_pco),
        .i_handler_count  (i_handler_count),
        .i_handler_bci    (i_handler_bci),
        .i_handler_pco    (i_handler_pco),
        .i_scope_depth    (i_scope_depth),
        .o_status         (o_status),
        .o_subtable_found (o_subtable_found),
        .o_subtable_len   (o_subtable_len),
        .o_found          (o_found),
        .o_found_pco      (o_found_pco)
    );

endmodule

// File: rtl/exh_ctrl.sv
// Control state machine that sequences each transaction through the datapath.
module exh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  exh_pkg::t_dp_stat i_stat,
    output exh_pkg::t_dp_cmd  o_cmd
);

    exh_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= exh_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.stat  = exh_pkg::ST_OK;
        o_ready     = 1'b0;
        n_out_valid = r_out_valid && !i_ready;

        case (r_state)
            exh_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = exh_pkg::S_DECODE;
                end
            end
            exh_pkg::S_DECODE: begin
                case (i_stat.func)
                    exh_pkg::FUNC_ENTRY: begin
                        if (i_stat.pending_zero) begin
                            o_cmd.set_stat = 1'b1;
                            o_cmd.stat     = exh_pkg::ST_SEQ;
                        end else if (i_stat.fill_full) begin
                            o_cmd.set_stat = 1'b1;
                            o_cmd.stat     = exh_pkg::ST_FULL;
                        end else begin
                            o_cmd.entry_wr = 1'b1;
                        end
                        n_state = exh_pkg::S_FINISH;
                    end
                    exh_pkg::FUNC_HDR, exh_pkg::FUNC_LOOKUP: begin
                        if (i_stat.func == exh_pkg::FUNC_HDR && !i_stat.pending_zero) begin
                            o_cmd.set_stat = 1'b1;
                            o_cmd.stat     = exh_pkg::ST_SEQ;
                            n_state        = exh_pkg::S_FINISH;
                        end else if (i_stat.fill_zero) begin
                            n_state = exh_pkg::S_RESOLVE;
                        end else begin
                            o_cmd.walk_start = 1'b1;
                            n_state          = exh_pkg::S_WALK;
                        end
                    end
                    default: begin
                        o_cmd.set_stat = 1'b1;
                        o_cmd.stat     = exh_pkg::ST_SEQ;
                        n_state        = exh_pkg::S_FINISH;
                    end
                endcase
            end
            exh_pkg::S_WALK: begin
                if (i_stat.walk_match) begin
                    o_cmd.walk_hit = 1'b1;
                    n_state        = exh_pkg::S_RESOLVE;
                end else if (i_stat.walk_more) begin
                    o_cmd.walk_step = 1'b1;
                end else begin
                    n_state = exh_pkg::S_RESOLVE;
                end
            end
            exh_pkg::S_RESOLVE: begin
                n_state = exh_pkg::S_FINISH;
                if (i_stat.func == exh_pkg::FUNC_HDR) begin
                    if (i_stat.hit) begin
                        o_cmd.set_stat = 1'b1;
                        o_cmd.stat     = exh_pkg::ST_DUP;
                    end else if (i_stat.cnt_zero) begin
                        o_cmd.set_stat = 1'b0;
                    end else if (!i_stat.hdr_fits) begin
                        o_cmd.set_stat = 1'b1;
                        o_cmd.stat     = exh_pkg::ST_FULL;
                    end else begin
                        o_cmd.hdr_wr = 1'b1;
                    end
                end else if (i_stat.hit) begin
                    o_cmd.scan_start = 1'b1;
                    if (!i_stat.hdr_cnt_zero && i_stat.scan_first_ok) begin
                        n_state = exh_pkg::S_SCAN;
                    end
                end
            end
            exh_pkg::S_SCAN: begin
                if (i_stat.scan_match) begin
                    o_cmd.scan_hit = 1'b1;
                    n_state        = exh_pkg::S_FINISH;
                end else if (i_stat.scan_more) begin
                    o_cmd.scan_step = 1'b1;
                end else begin
                    n_state = exh_pkg::S_FINISH;
                end
            end
            exh_pkg::S_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = exh_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = exh_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid = r_out_valid;

endmodule

// File: rtl/exh_dp.sv
// Datapath: table memory, fill and pending counters, walk pointers and result registers.
module exh_dp #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  exh_pkg::t_dp_cmd  i_cmd,
    output exh_pkg::t_dp_stat o_stat,
    input  logic [1:0]        i_func,
    input  logic [31:0]       i_site_pco,
    input  logic [7:0]        i_handler_count,
    input  logic [15:0]       i_handler_bci,
    input  logic [31:0]       i_handler_pco,
    input  logic [7:0]        i_scope_depth,
    output logic [1:0]        o_status,
    output logic              o_subtable_found,
    output logic [7:0]        o_subtable_len,
    output logic              o_found,
    output logic [31:0]       o_found_pco
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int PTR_W = AW + 1;
    localparam int SUM_W = ((PTR_W > 8) ? PTR_W : 8) + 1;

    logic [55:0] r_mem [TABLE_DEPTH];
    logic [55:0] r_rd_data;

    logic [PTR_W-1:0] r_fill;
    logic [7:0]       r_pending;

    logic [1:0]  r_func;
    logic [31:0] r_cpco;
    logic [7:0]  r_cnt;
    logic [15:0] r_bci;
    logic [31:0] r_hpco;
    logic [7:0]  r_depth;

    logic [PTR_W-1:0] r_ptr;
    logic [AW-1:0]    r_hdr_ptr;
    logic [7:0]       r_hdr_cnt;
    logic [7:0]       r_remain;

    logic        r_hit;
    logic [1:0]  r_stat;
    logic        r_sfound;
    logic [7:0]  r_slen;
    logic        r_found;
    logic [31:0] r_fpco;

    logic [SUM_W-1:0] walk_next;
    logic [SUM_W-1:0] hdr_end;
    logic [PTR_W-1:0] ptr_inc;
    logic [PTR_W-1:0] hdr_inc;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [55:0]      wr_data;

    assign walk_next = SUM_W'(r_ptr) + SUM_W'(r_rd_data[39:32]) + SUM_W'(1);
    assign hdr_end   = SUM_W'(r_fill) + SUM_W'(r_cnt) + SUM_W'(1);
    assign ptr_inc   = r_ptr + PTR_W'(1);
    assign hdr_inc   = PTR_W'(r_hdr_ptr) + PTR_W'(1);

    always_comb begin
        rd_en   = 1'b1;
        rd_addr = '0;
        if (i_cmd.walk_step) begin
            rd_addr = walk_next[AW-1:0];
        end else if (i_cmd.scan_start) begin
            rd_addr = hdr_inc[AW-1:0];
        end else if (i_cmd.scan_step) begin
            rd_addr = ptr_inc[AW-1:0];
        end else if (!i_cmd.walk_start) begin
            rd_en = 1'b0;
        end
    end

    assign wr_en   = i_cmd.entry_wr || i_cmd.hdr_wr;
    assign wr_data = i_cmd.hdr_wr ? {16'd0, r_cnt, r_cpco} : {r_depth, r_bci, r_hpco};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_fill[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_pending <= '0;
        end else if (i_cmd.hdr_wr) begin
            r_fill    <= r_fill + PTR_W'(1);
            r_pending <= r_cnt;
        end else if (i_cmd.entry_wr) begin
            r_fill    <= r_fill + PTR_W'(1);
            r_pending <= r_pending - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func   <= i_func;
            r_cpco   <= i_site_pco;
            r_cnt    <= i_handler_count;
            r_bci    <= i_handler_bci;
            r_hpco   <= i_handler_pco;
            r_depth  <= i_scope_depth;
            r_hit    <= 1'b0;
            r_stat   <= exh_pkg::ST_OK;
            r_sfound <= 1'b0;
            r_slen   <= '0;
            r_found  <= 1'b0;
            r_fpco   <= '0;
        end
        if (i_cmd.set_stat) begin
            r_stat <= i_cmd.stat;
        end
        if (i_cmd.walk_start) begin
            r_ptr <= '0;
        end
        if (i_cmd.walk_step) begin
            r_ptr <= walk_next[PTR_W-1:0];
        end
        if (i_cmd.walk_hit) begin
            r_hit     <= 1'b1;
            r_hdr_ptr <= r_ptr[AW-1:0];
            r_hdr_cnt <= r_rd_data[39:32];
        end
        if (i_cmd.scan_start) begin
            r_sfound <= 1'b1;
            r_slen   <= r_hdr_cnt;
            r_ptr    <= hdr_inc;
            r_remain <= r_hdr_cnt;
        end
        if (i_cmd.scan_step) begin
            r_ptr    <= ptr_inc;
            r_remain <= r_remain - 8'd1;
        end
        if (i_cmd.scan_hit) begin
            r_found <= 1'b1;
            r_fpco  <= r_rd_data[31:0];
        end
        if (i_cmd.out_load) begin
            o_status         <= r_stat;
            o_subtable_found <= r_sfound;
            o_subtable_len   <= r_slen;
            o_found          <= r_found;
            o_found_pco      <= r_fpco;
        end
    end

    always_comb begin
        o_stat.func          = exh_pkg::t_func'(r_func);
        o_stat.pending_zero  = (r_pending == 8'd0);
        o_stat.fill_zero     = (r_fill == '0);
        o_stat.fill_full     = (r_fill >= PTR_W'(TABLE_DEPTH));
        o_stat.cnt_zero      = (r_cnt == 8'd0);
        o_stat.hdr_fits      = (hdr_end <= SUM_W'(TABLE_DEPTH));
        o_stat.walk_match    = (r_rd_data[31:0] == r_cpco);
        o_stat.walk_more     = (walk_next < SUM_W'(r_fill));
        o_stat.hit           = r_hit;
        o_stat.hdr_cnt_zero  = (r_hdr_cnt == 8'd0);
        o_stat.scan_first_ok = (hdr_inc < r_fill);
        o_stat.scan_match    = (r_rd_data[47:32] == r_bci) && (r_rd_data[55:48] == r_depth);
        o_stat.scan_more     = (r_remain > 8'd1) && (ptr_inc < r_fill);
    end

endmodule

// File: rtl/exh_checker.sv
// Port-level checks for the exception handler table and their binding.
module exh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic        o_subtable_found,
    input logic [7:0]  o_subtable_len,
    input logic        o_found,
    input logic [31:0] o_found_pco
);

    // A stalled result holds its status, subtable length, found flag and handler offset.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_found)
            && $stable(o_found_pco) && $stable(o_subtable_len))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Only a lookup, which always reports ok, can find anything.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != exh_pkg::ST_OK |-> !o_subtable_found && !o_found
            && o_subtable_len == 8'd0 && o_found_pco == 32'd0)
        else $error("failed item reports lookup data");

    // A handler match requires its subtable to have been found.
    a_found_needs_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_subtable_found |-> !o_found && o_subtable_len == 8'd0)
        else $error("match without subtable");

    // Without a match the handler offset is zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_found_pco == 32'd0)
        else $error("offset reported without match");

endmodule

bind exception_handler_table exh_checker u_exh_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_status         (o_status),
    .o_subtable_found (o_subtable_found),
    .o_subtable_len   (o_subtable_len),
    .o_found          (o_found),
    .o_found_pco      (o_found_pco)
);

// File: test/testbench.sv
// Self-checking testbench for the exception handler table, with its own prediction of every result.
`timescale 1ns / 100ps

module testbench;

    localparam int TABLE_DEPTH = 256;

    // The selector code that has no meaning in the package.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Drain time after the last result: a full lookup walk plus some margin.
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;

    // One input transaction, as offered on the item ports.
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] site_pco;
        logic [7:0]  count;
        logic [15:0] bci;
        logic [31:0] hpco;
        logic [7:0]  depth;
    } t_item;

    // One result transaction, as seen on the result ports.
    typedef struct packed {
        exh_pkg::t_status status;
        logic             sfound;
        logic [7:0]       len;
        logic             found;
        logic [31:0]      fpco;
    } t_response;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_func = exh_pkg::FUNC_HDR;
    logic [31:0] i_site_pco = '0;
    logic [7:0]  i_handler_count = '0;
    logic [15:0] i_handler_bci = '0;
    logic [31:0] i_handler_pco = '0;
    logic [7:0]  i_scope_depth = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic        o_subtable_found;
    logic [7:0]  o_subtable_len;
    logic        o_found;
    logic [31:0] o_found_pco;

    exception_handler_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_site_pco      (i_site_pco),
        .i_handler_count (i_handler_count),
        .i_handler_bci   (i_handler_bci),
        .i_handler_pco   (i_handler_pco),
        .i_scope_depth   (i_scope_depth),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_subtable_found(o_subtable_found),
        .o_subtable_len  (o_subtable_len),
        .o_found         (o_found),
        .o_found_pco     (o_found_pco)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Items waiting to be offered, and results predicted but not yet seen.
    t_item     item_backlog[$];
    t_response pending_responses[$];

    // Shadow copy of the table. Only words below shadow_fill are ever read.
    logic [55:0] shadow_tbl[TABLE_DEPTH];
    int          shadow_fill = 0;
    int          shadow_owed = 0;

    // Knobs that the sequencing block turns between phases.
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic send_hold = 1'b0;
    logic recv_block = 1'b0;
    logic stall_go = 1'b0;

    int err_cnt = 0;
    int items_queued = 0;
    int items_taken = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int handler_hits = 0;

    // Index of the header whose catch offset matches, or -1. The walk hops
    // from header to header by each header's entry count.
    function automatic int find_header(input logic [31:0] pco);
        int idx;
        int hit;
        idx = 0;
        hit = -1;
        while (hit < 0 && idx < shadow_fill) begin
            if (shadow_tbl[idx][31:0] == pco)
                hit = idx;
            else
                idx += int'(shadow_tbl[idx][39:32]) + 1;
        end
        return hit;
    endfunction

    // Works out the result of one accepted item and updates the shadow table.
    function automatic t_response table_response(input t_item it);
        t_response r;
        int        h;
        int        n;
        int        p;
        r = '0;
        r.status = exh_pkg::ST_OK;
        case (it.func)
            exh_pkg::FUNC_HDR: begin
                // The duplicate check comes before the zero-count case.
                if (shadow_owed != 0)
                    r.status = exh_pkg::ST_SEQ;
                else if (find_header(it.site_pco) >= 0)
                    r.status = exh_pkg::ST_DUP;
                else if (it.count == 8'd0)
                    r.status = exh_pkg::ST_OK;
                else if (shadow_fill + 1 + int'(it.count) > TABLE_DEPTH)
                    r.status = exh_pkg::ST_FULL;
                else begin
                    shadow_tbl[shadow_fill] = {16'd0, it.count, it.site_pco};
                    shadow_fill++;
                    shadow_owed = int'(it.count);
                end
            end
            exh_pkg::FUNC_ENTRY: begin
                if (shadow_owed == 0)
                    r.status = exh_pkg::ST_SEQ;
                else if (shadow_fill >= TABLE_DEPTH)
                    r.status = exh_pkg::ST_FULL;
                else begin
                    shadow_tbl[shadow_fill] = {it.depth, it.bci, it.hpco};
                    shadow_fill++;
                    shadow_owed--;
                end
            end
            exh_pkg::FUNC_LOOKUP: begin
                h = find_header(it.site_pco);
                if (h >= 0) begin
                    n = int'(shadow_tbl[h][39:32]);
                    r.sfound = 1'b1;
                    r.len = shadow_tbl[h][39:32];
                    // A subtable that is still open is searched only as far
                    // as its entries have been written.
                    for (int k = 1; k <= n && !r.found; k++) begin
                        p = h + k;
                        if (p < shadow_fill && shadow_tbl[p][47:32] == it.bci &&
                                shadow_tbl[p][55:48] == it.depth) begin
                            r.found = 1'b1;
                            r.fpco = shadow_tbl[p][31:0];
                        end
                    end
                end
            end
            default: begin
                r.status = exh_pkg::ST_SEQ;
            end
        endcase
        return r;
    endfunction

    // Driver: offers the next backlog item when the port is free, unless held or idling. An
    // item is predicted at the edge where its transaction completes.
    always @(posedge i_clk) begin
        t_item     taken;
        t_response resp;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                taken = '{i_func, i_site_pco, i_handler_count, i_handler_bci,
                          i_handler_pco, i_scope_depth};
                resp = table_response(taken);
                pending_responses.push_back(resp);
                items_taken++;
                status_seen[resp.status]++;
                if (resp.found)
                    handler_hits++;
            end
            if (!i_valid || o_ready) begin
                if (item_backlog.size() > 0 && !send_hold &&
                        $urandom_range(0, 99) >= send_idle_pct) begin
                    taken = item_backlog.pop_front();
                    i_func          <= taken.func;
                    i_site_pco      <= taken.site_pco;
                    i_handler_count <= taken.count;
                    i_handler_bci   <= taken.bci;
                    i_handler_pco   <= taken.hpco;
                    i_scope_depth   <= taken.depth;
                    i_valid         <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Monitor: checks every result transaction against the oldest prediction
    // and decides whether the receiver takes a result on the next edge.
    always @(posedge i_clk) begin
        t_response want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_responses.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result with no item outstanding, status %0d pco %0h",
                             $time, o_status, o_found_pco);
                end else begin
                    want = pending_responses.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("subtable_found", 32'(want.sfound), 32'(o_subtable_found));
                    check_field("subtable_len", 32'(want.len), 32'(o_subtable_len));
                    check_field("found", 32'(want.found), 32'(o_found));
                    check_field("found_pco", want.fpco, o_found_pco);
                end
            end
            i_ready <= !recv_block && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Long receiver hold-off: the input side keeps offering items, so the
    // block fills its pipeline and has to drop its ready.
    initial begin
        wait (stall_go);
        @(posedge i_clk);
        recv_block <= 1'b1;
        repeat (400) @(posedge i_clk);
        recv_block <= 1'b0;
    end

    task automatic push_item(input logic [1:0] func, input logic [31:0] cpco,
                             input logic [7:0] cnt, input logic [15:0] bci,
                             input logic [31:0] hpco, input logic [7:0] depth);
        item_backlog.push_back('{func, cpco, cnt, bci, hpco, depth});
        items_queued++;
    endtask

    // Header index of a randomly chosen stored subtable, or -1 if none.
    function automatic int pick_subtable();
        int idx;
        int total;
        int want;
        total = 0;
        idx = 0;
        while (idx < shadow_fill) begin
            total++;
            idx += int'(shadow_tbl[idx][39:32]) + 1;
        end
        if (total == 0)
            return -1;
        want = $urandom_range(0, total - 1);
        idx = 0;
        for (int s = 0; s < want; s++)
            idx += int'(shadow_tbl[idx][39:32]) + 1;
        return idx;
    endfunction

    // A lookup that mostly targets a stored entry, so that the walk and the
    // scan both run deep; the rest miss on the offset, the index or the depth.
    task automatic queue_lookup();
        int          h;
        int          n;
        int          p;
        logic [31:0] pco;
        logic [15:0] bci;
        logic [7:0]  depth;
        h = ($urandom_range(0, 5) != 0) ? pick_subtable() : -1;
        pco = $urandom();
        bci = 16'($urandom_range(0, 65535));
        depth = 8'($urandom_range(0, 2));
        if (h >= 0) begin
            pco = shadow_tbl[h][31:0];
            n = int'(shadow_tbl[h][39:32]);
            p = h + $urandom_range(1, (n > 0) ? n : 1);
            if (n > 0 && p < shadow_fill && $urandom_range(0, 3) != 0) begin
                bci = shadow_tbl[p][47:32];
                depth = shadow_tbl[p][55:48];
                if ($urandom_range(0, 7) == 0)
                    depth ^= 8'd1;
            end
        end
        push_item(exh_pkg::FUNC_LOOKUP, pco, 8'($urandom_range(0, 255)), bci, $urandom(),
                  depth);
    endtask

    // A header followed by its entries, now and then with a lookup or a stray
    // header in the middle, or with an entry left out.
    task automatic queue_subtable();
        int          h;
        int          sel;
        int          room;
        logic [31:0] pco;
        logic [7:0]  cnt;
        h = ($urandom_range(0, 9) == 0) ? pick_subtable() : -1;
        pco = (h >= 0) ? shadow_tbl[h][31:0] : $urandom();
        sel = $urandom_range(0, 99);
        room = TABLE_DEPTH - 1 - shadow_fill;
        if (sel < 10)
            cnt = 8'd0;
        else if (sel < 80)
            cnt = 8'($urandom_range(1, 4));
        else if (sel < 90)
            cnt = 8'($urandom_range(5, 16));
        else if (sel < 95 && room >= 1 && room <= 255)
            cnt = 8'(room);   // exactly fills the table
        else
            cnt = 8'($urandom_range(0, 255));
        push_item(exh_pkg::FUNC_HDR, pco, cnt, 16'($urandom_range(0, 65535)), $urandom(),
                  8'($urandom_range(0, 255)));
        // A subtable that cannot fit gets no entries beyond one stray.
        if (shadow_fill + 1 + int'(cnt) > TABLE_DEPTH)
            cnt = (cnt != 0) ? 8'd1 : 8'd0;
        for (int k = 0; k < int'(cnt); k++) begin
            sel = $urandom_range(0, 119);
            if (sel < 3)
                queue_lookup();
            else if (sel < 5)
                push_item(exh_pkg::FUNC_HDR, $urandom(), 8'($urandom_range(1, 3)),
                          '0, '0, '0);
            if (sel != 5)
                push_item(exh_pkg::FUNC_ENTRY, $urandom(), 8'($urandom_range(0, 255)),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7))
                                                      : 16'($urandom_range(0, 65535)),
                          $urandom(),
                          ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                      : 8'($urandom_range(0, 2)));
        end
    endtask

    // Random traffic until about n more items are queued. The backlog is kept
    // short so that choices made here see a nearly current shadow table.
    task automatic queue_random(input int n);
        int stop_at;
        int sel;
        stop_at = items_queued + n;
        while (items_queued < stop_at) begin
            while (item_backlog.size() > 2)
                @(negedge i_clk);
            sel = $urandom_range(0, 99);
            if (sel < 40)
                queue_subtable();
            else if (sel < 85)
                queue_lookup();
            else
                push_item(2'($urandom_range(0, 3)), $urandom(), 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)), $urandom(),
                          8'($urandom_range(0, 255)));
        end
    endtask

    // Pause the sender until every outstanding result has come back.
    task automatic drain();
        while (item_backlog.size() > 0)
            @(negedge i_clk);
        send_hold = 1'b1;
        while (i_valid || pending_responses.size() > 0)
            @(negedge i_clk);
        send_hold = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: empty table, sequencing errors, the unused selector,
        // an open subtable being searched, duplicates and a header too big to fit.
        push_item(exh_pkg::FUNC_LOOKUP, 32'h0, 8'd0, 16'h0, 32'h0, 8'h0);
        push_item(exh_pkg::FUNC_ENTRY, 32'h0, 8'd0, 16'h1, 32'h1, 8'h1);
        push_item(FUNC_UNUSED, '1, '1, '1, '1, '1);
        push_item(exh_pkg::FUNC_HDR, 32'h0, 8'd0, 16'h0, 32'h0, 8'h0);
        push_item(exh_pkg::FUNC_HDR, 32'hFFFF_FFFF, 8'd3, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        push_item(exh_pkg::FUNC_ENTRY, 32'h0, 8'd0, 16'h0, 32'h0, 8'h0);
        push_item(exh_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 8'd0, 16'h0, 32'h0, 8'h0);
        push_item(exh_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 8'd0, 16'hFFFF, 32'h0, 8'hFF);
        push_item(exh_pkg::FUNC_HDR, 32'h5, 8'd1, 16'h0, 32'h0, 8'h0);
        push_item(exh_pkg::FUNC_ENTRY, 32'h0, 8'd0, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
        push_item(exh_pkg::FUNC_ENTRY, 32'h0, 8'd0, 16'h1234, 32'h8765_4321, 8'h0);
        push_item(exh_pkg::FUNC_ENTRY, 32'h0, 8'd0, 16'h1234, 32'h1111_1111, 8'h0);
        push_item(exh_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 8'd0, 16'hFFFF, 32'h0, 8'hFF);
        push_item(exh_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 8'd0, 16'hFFFF, 32'h0, 8'h0);
        push_item(exh_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 8'd0, 16'h1234, 32'h0, 8'h0);
        push_item(exh_pkg::FUNC_HDR, 32'hFFFF_FFFF, 8'd0, 16'h0, 32'h0, 8'h0);
        push_item(exh_pkg::FUNC_HDR, 32'hFFFF_FFFF, 8'd2, 16'h0, 32'h0, 8'h0);
        push_item(exh_pkg::FUNC_HDR, 32'h0, 8'd1, 16'h0, 32'h0, 8'h0);
        push_item(exh_pkg::FUNC_ENTRY, 32'h0, 8'd0, 16'h00AA, 32'hA5A5_5A5A, 8'h7);
        push_item(exh_pkg::FUNC_LOOKUP, 32'h0, 8'd0, 16'h00AB, 32'h0, 8'h7);
        push_item(exh_pkg::FUNC_LOOKUP, 32'h0, 8'd0, 16'h00AA, 32'h0, 8'h7);
        push_item(exh_pkg::FUNC_HDR, 32'h1234_5678, 8'd255, 16'h0, 32'h0, 8'h0);
        push_item(exh_pkg::FUNC_LOOKUP, 32'h1234_5678, 8'd0, 16'h0, 32'h0, 8'h0);
        drain();

        // Sender idles rarely while the receiver idles most of the time.
        send_idle_pct = 13;
        recv_idle_pct = 78;
        queue_random(510);
        drain();

        // The other way round.
        send_idle_pct = 78;
        recv_idle_pct = 13;
        queue_random(510);
        drain();

        // Full rate on both sides, with one long receiver hold-off inside.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(120);
        stall_go = 1'b1;
        queue_random(390);
        drain();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d items: %0d ok, %0d table full, %0d duplicate, %0d out of sequence.",
                 items_taken, status_seen[exh_pkg::ST_OK], status_seen[exh_pkg::ST_FULL],
                 status_seen[exh_pkg::ST_DUP], status_seen[exh_pkg::ST_SEQ]);
        $display("Lookups found %0d handlers; the table ended with %0d of %0d words in use.",
                 handler_hits, shadow_fill, TABLE_DEPTH);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: several times the slowest correct run, in which every lookup
    // walks the whole table and every result waits out a long receiver stall.
    initial begin
        #25_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
